>>> rtl/tdr_pkg.sv
// ----------------------------------------------------------------------------
// tdr_pkg: shared types and constants for the time-of-day register
// Command and response beats, the work item that moves down the digit
// pipeline, and the reciprocal constants used for the constant divisions.
// ----------------------------------------------------------------------------
package tdr_pkg;

	// Command kinds
	localparam logic KindAdd = 1'b0;
	localparam logic KindSet = 1'b1;

	// Component / unit codes
	localparam logic [1:0] UnitMs   = 2'd0;
	localparam logic [1:0] UnitSec  = 2'd1;
	localparam logic [1:0] UnitMin  = 2'd2;
	localparam logic [1:0] UnitHour = 2'd3;

	// Radix of each component
	localparam logic [10:0] RadixMs   = 11'd1000;
	localparam logic [10:0] RadixSec  = 11'd60;
	localparam logic [10:0] RadixMin  = 11'd60;
	localparam logic [10:0] RadixHour = 11'd24;

	// Reciprocal shifts: 2^k / radix fits in 32 bits and k >= 32, so the
	// estimated quotient is low by at most one
	localparam int unsigned ShiftMs    = 41;
	localparam int unsigned ShiftSixty = 37;
	localparam int unsigned ShiftHour  = 36;

	localparam logic [31:0] RecipMs    = 32'((64'd1 << ShiftMs) / 64'd1000);
	localparam logic [31:0] RecipSixty = 32'((64'd1 << ShiftSixty) / 64'd60);
	localparam logic [31:0] RecipHour  = 32'((64'd1 << ShiftHour) / 64'd24);

	// Number of digit extraction steps (ms, s, min, h)
	localparam int unsigned NumSteps = 4;

	typedef struct packed {
		logic              kind;
		logic [1:0]        unit;
		logic signed [31:0] amount;
	} tdr_in_t;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds_part;
		logic [9:0] millis;
		logic       bad_value;
	} tdr_out_t;

	// Item in flight: command, magnitude still to split, digits found so far
	typedef struct packed {
		logic        kind;
		logic [1:0]  unit;
		logic [31:0] raw;
		logic        neg;
		logic [31:0] x;
		logic [9:0]  d_ms;
		logic [5:0]  d_s;
		logic [5:0]  d_m;
		logic [4:0]  d_h;
	} tdr_work_t;

	function automatic logic [10:0] step_radix(input logic [1:0] pos);
		case (pos)
			UnitMs:   step_radix = RadixMs;
			UnitSec:  step_radix = RadixSec;
			UnitMin:  step_radix = RadixMin;
			default:  step_radix = RadixHour;
		endcase
	endfunction

	function automatic logic [31:0] step_recip(input logic [1:0] pos);
		case (pos)
			UnitMs:   step_recip = RecipMs;
			UnitSec:  step_recip = RecipSixty;
			UnitMin:  step_recip = RecipSixty;
			default:  step_recip = RecipHour;
		endcase
	endfunction

	function automatic logic [5:0] step_shift(input logic [1:0] pos);
		case (pos)
			UnitMs:   step_shift = 6'(ShiftMs);
			UnitSec:  step_shift = 6'(ShiftSixty);
			UnitMin:  step_shift = 6'(ShiftSixty);
			default:  step_shift = 6'(ShiftHour);
		endcase
	endfunction

endpackage

>>> rtl/tdr_digit_step.sv
// ----------------------------------------------------------------------------
// tdr_digit_step: one mixed-radix digit of the add magnitude
// Splits x into x mod radix and x / radix by reciprocal multiply, quotient
// estimate and one correction, over three pipeline registers.
// ----------------------------------------------------------------------------
module tdr_digit_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          pos,
	input  logic                up_valid,
	output logic                up_ready,
	input  tdr_pkg::tdr_work_t  up_work,
	output logic                down_valid,
	input  logic                down_ready,
	output tdr_pkg::tdr_work_t  down_work
);
	import tdr_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic        adv_s1, adv_s2, adv_s3;
	tdr_work_t   work_s1, work_s2, work_s3;
	logic [63:0] prod_s1;
	logic [31:0] q_s2;
	logic [10:0] rem_s2;

	logic [10:0] radix;
	logic [31:0] recip;
	logic [63:0] prod_d;
	logic [31:0] q_d;
	logic [31:0] qr_d;
	logic [31:0] rem_full;
	logic        fix;
	logic [10:0] digit;
	logic [31:0] q_fix;
	tdr_work_t   next_work;

	assign radix = step_radix(pos);
	assign recip = step_recip(pos);

	// Stage handshake: a stage moves when it is empty or the next one moves
	assign adv_s3   = !v_s3 || down_ready;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign up_ready = adv_s1;

	assign down_valid = v_s3;
	assign down_work  = work_s3;

	// Reciprocal product
	assign prod_d = 64'(up_work.x) * 64'(recip);

	// Quotient estimate and remainder estimate in [0, 2*radix)
	assign q_d      = 32'(prod_s1 >> step_shift(pos));
	assign qr_d     = q_d * 32'(radix);
	assign rem_full = work_s1.x - qr_d;

	// Correction and digit placement
	always_comb begin
		fix       = (rem_s2 >= radix);
		digit     = fix ? (rem_s2 - radix) : rem_s2;
		q_fix     = q_s2 + 32'(fix);
		next_work = work_s2;
		// digits below the command's unit stay zero, x passes untouched
		if (work_s2.unit <= pos) begin
			next_work.x = q_fix;
			case (pos)
				UnitMs:  next_work.d_ms = digit[9:0];
				UnitSec: next_work.d_s  = digit[5:0];
				UnitMin: next_work.d_m  = digit[5:0];
				default: next_work.d_h  = digit[4:0];
			endcase
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= up_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) begin
			work_s1 <= up_work;
			prod_s1 <= prod_d;
		end
		if (adv_s2 && v_s1) begin
			work_s2 <= work_s1;
			q_s2    <= q_d;
			rem_s2  <= rem_full[10:0];
		end
		if (adv_s3 && v_s2) begin
			work_s3 <= next_work;
		end
	end

endmodule

>>> rtl/tdr_update.sv
// ----------------------------------------------------------------------------
// tdr_update: time state and response register
// Turns a negative add into its complement modulo one day, then adds the
// digits to the held time with carries, or replaces one component.
// ----------------------------------------------------------------------------
module tdr_update (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  tdr_pkg::tdr_work_t  up_work,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output tdr_pkg::tdr_out_t   rsp
);
	import tdr_pkg::*;

	logic      v_s1;
	logic      adv_s1, adv_out;
	tdr_work_t work_s1;
	tdr_work_t cmp_work;
	logic      rsp_valid_q;
	tdr_out_t  rsp_q;

	// held time, in components
	logic [4:0] hour_q;
	logic [5:0] min_q;
	logic [5:0] sec_q;
	logic [9:0] ms_q;

	// complement scratch
	logic       b0, b1, b2;
	logic [6:0] ts, tm;
	logic [5:0] th;

	// add / set scratch
	logic [10:0] ms_sum;
	logic [6:0]  s_sum, m_sum;
	logic [5:0]  h_sum;
	logic        c0, c1, c2;
	tdr_out_t    next_rsp;

	assign adv_out  = !rsp_valid_q || rsp_ready;
	assign adv_s1   = !v_s1 || adv_out;
	assign up_ready = adv_s1;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Negative add: digits become (one day - value), borrowing upward
	always_comb begin
		cmp_work = up_work;
		b0 = (up_work.d_ms != 10'd0);
		ts = 7'(up_work.d_s) + 7'(b0);
		b1 = (ts != 7'd0);
		tm = 7'(up_work.d_m) + 7'(b1);
		b2 = (tm != 7'd0);
		th = 6'(up_work.d_h) + 6'(b2);
		if (up_work.kind == KindAdd && up_work.neg) begin
			cmp_work.d_ms = b0 ? 10'(RadixMs - 11'(up_work.d_ms)) : 10'd0;
			cmp_work.d_s  = b1 ? 6'(7'(RadixSec) - ts) : 6'd0;
			cmp_work.d_m  = b2 ? 6'(7'(RadixMin) - tm) : 6'd0;
			cmp_work.d_h  = (th != 6'd0) ? 5'(6'(RadixHour) - th) : 5'd0;
		end
	end

	// Add with carries, or replace one component
	always_comb begin
		ms_sum = 11'(ms_q) + 11'(work_s1.d_ms);
		c0     = (ms_sum >= RadixMs);
		s_sum  = 7'(sec_q) + 7'(work_s1.d_s) + 7'(c0);
		c1     = (s_sum >= 7'(RadixSec));
		m_sum  = 7'(min_q) + 7'(work_s1.d_m) + 7'(c1);
		c2     = (m_sum >= 7'(RadixMin));
		h_sum  = 6'(hour_q) + 6'(work_s1.d_h) + 6'(c2);

		next_rsp.hours        = hour_q;
		next_rsp.minutes      = min_q;
		next_rsp.seconds_part = sec_q;
		next_rsp.millis       = ms_q;
		next_rsp.bad_value    = 1'b0;

		if (work_s1.kind == KindAdd) begin
			next_rsp.millis       = 10'(c0 ? (ms_sum - RadixMs) : ms_sum);
			next_rsp.seconds_part = 6'(c1 ? (s_sum - 7'(RadixSec)) : s_sum);
			next_rsp.minutes      = 6'(c2 ? (m_sum - 7'(RadixMin)) : m_sum);
			next_rsp.hours        = 5'((h_sum >= 6'(RadixHour)) ?
			                           (h_sum - 6'(RadixHour)) : h_sum);
		end else begin
			case (work_s1.unit)
				UnitMs: begin
					if (work_s1.raw < 32'(RadixMs)) next_rsp.millis = work_s1.raw[9:0];
					else next_rsp.bad_value = 1'b1;
				end
				UnitSec: begin
					if (work_s1.raw < 32'(RadixSec)) next_rsp.seconds_part = work_s1.raw[5:0];
					else next_rsp.bad_value = 1'b1;
				end
				UnitMin: begin
					if (work_s1.raw < 32'(RadixMin)) next_rsp.minutes = work_s1.raw[5:0];
					else next_rsp.bad_value = 1'b1;
				end
				default: begin
					if (work_s1.raw < 32'(RadixHour)) next_rsp.hours = work_s1.raw[4:0];
					else next_rsp.bad_value = 1'b1;
				end
			endcase
		end
	end

	// Control and time state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
			hour_q      <= 5'd0;
			min_q       <= 6'd0;
			sec_q       <= 6'd0;
			ms_q        <= 10'd0;
		end else begin
			if (adv_s1) v_s1 <= up_valid;
			if (adv_out) rsp_valid_q <= v_s1;
			if (adv_out && v_s1) begin
				hour_q <= next_rsp.hours;
				min_q  <= next_rsp.minutes;
				sec_q  <= next_rsp.seconds_part;
				ms_q   <= next_rsp.millis;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) work_s1 <= cmp_work;
		if (adv_out && v_s1) rsp_q <= next_rsp;
	end

endmodule

>>> rtl/time_of_day_register.sv
// ----------------------------------------------------------------------------
// time_of_day_register: millisecond time of day with add and set commands
// Keeps hour, minute, second and millisecond; adds a signed scaled count
// modulo one day or replaces one component, one response beat per command.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | beat
//  ---------+-----+----------------------+--------------------------------
//  cmd      | in  | cmd_valid/cmd_ready  | kind, unit, amount
//  rsp      | out | rsp_valid/rsp_ready  | hours, minutes, seconds_part,
//           |     |                      | millis, bad_value
//
// One command per cycle sustained while rsp_ready stays high; from cmd beat to
// rsp_valid: input register, four digit steps of three registers each
// (reciprocal multiply, quotient estimate, correction), complement, response.
// The time state updates in the last stage, so commands act strictly in order.
// Reset gives midnight and empties the pipeline; a stalled rsp holds and stages
// behind it fill until cmd_ready drops.
// ----------------------------------------------------------------------------
module time_of_day_register (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  tdr_pkg::tdr_in_t  cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tdr_pkg::tdr_out_t rsp
);
	import tdr_pkg::*;

	logic      v_s1;
	tdr_work_t work_s1;
	tdr_work_t work_d;
	logic [31:0] raw;

	logic      stage_valid [NumSteps+1];
	logic      stage_ready [NumSteps+1];
	tdr_work_t stage_work  [NumSteps+1];

	// Input beat: sign and magnitude of the amount, digits cleared
	assign raw = cmd.amount;
	always_comb begin
		work_d      = '0;
		work_d.kind = cmd.kind;
		work_d.unit = cmd.unit;
		work_d.raw  = raw;
		work_d.neg  = raw[31];
		work_d.x    = raw[31] ? (~raw + 32'd1) : raw;
	end

	assign cmd_ready = !v_s1 || stage_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_ready) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) work_s1 <= work_d;
	end

	assign stage_valid[0] = v_s1;
	assign stage_work[0]  = work_s1;

	// Digit steps: ms, s, min, h
	for (genvar i = 0; i < NumSteps; i++) begin : g_step
		tdr_digit_step u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.pos        (2'(i)),
			.up_valid   (stage_valid[i]),
			.up_ready   (stage_ready[i]),
			.up_work    (stage_work[i]),
			.down_valid (stage_valid[i+1]),
			.down_ready (stage_ready[i+1]),
			.down_work  (stage_work[i+1])
		);
	end

	// Time state and response
	tdr_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (stage_valid[NumSteps]),
		.up_ready  (stage_ready[NumSteps]),
		.up_work   (stage_work[NumSteps]),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

>>> rtl/tdr_checker.sv
// ----------------------------------------------------------------------------
// tdr_port_checks: port-level checks for the time-of-day register
// Watches the command and response channels and checks ranges, a held stalled
// response, a pending command per response and the unchanged time on a rejected set.
// ----------------------------------------------------------------------------
module tdr_port_checks (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input tdr_pkg::tdr_out_t rsp
);

	logic [4:0] pend_q;
	logic       have_prev_q;
	logic [4:0] prev_h_q;
	logic [5:0] prev_m_q;
	logic [5:0] prev_s_q;
	logic [9:0] prev_ms_q;
	logic       cmd_beat, rsp_beat;

	assign cmd_beat = cmd_valid && cmd_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	// Commands in flight and the last delivered time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 5'd0;
			have_prev_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 5'(cmd_beat) - 5'(rsp_beat);
			if (rsp_beat) have_prev_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_beat) begin
			prev_h_q  <= rsp.hours;
			prev_m_q  <= rsp.minutes;
			prev_s_q  <= rsp.seconds_part;
			prev_ms_q <= rsp.millis;
		end
	end

	a_rsp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.hours < 5'd24) && (rsp.minutes < 6'd60) &&
		              (rsp.seconds_part < 6'd60) && (rsp.millis < 10'd1000))
		else $error("response time out of range");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_rsp_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 5'd0)
		else $error("response without a pending command");

	a_bad_keeps_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_value && have_prev_q |->
			rsp.hours == prev_h_q && rsp.minutes == prev_m_q &&
			rsp.seconds_part == prev_s_q && rsp.millis == prev_ms_q)
		else $error("rejected set changed the time");

endmodule

bind time_of_day_register tdr_port_checks u_tdr_port_checks (.*);

>>> bench/tdr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_checker: response checker for the time-of-day register
// Watches the command and response channels. It keeps its own copy of the
// millisecond clock, predicts the response to every accepted command, and
// compares each response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tdr_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_ready,
	input  tdr_pkg::tdr_in_t  cmd,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  tdr_pkg::tdr_out_t rsp,
	output int                errors,
	output int                pending,
	output int                responses,
	output int                rejects
);
	import tdr_pkg::*;

	localparam longint SecondMs = 1000;
	localparam longint MinuteMs = 60000;
	localparam longint HourMs   = 3600000;
	localparam longint DayMs    = 86400000;

	logic [26:0] clock_ms;
	tdr_out_t    expected_times[$];

	// Apply one command to the local clock and return the time it reports
	function automatic tdr_out_t predict_time(input tdr_in_t c);
		longint      scale;
		longint      total;
		int unsigned now;
		int unsigned raw;
		int unsigned hh, mm, ss, ff;
		logic        rejected;
		tdr_out_t    r;
		now = 32'(clock_ms);
		raw = c.amount;
		rejected = 1'b0;
		if (c.kind == KindAdd) begin
			case (c.unit)
				UnitMs:  scale = 1;
				UnitSec: scale = SecondMs;
				UnitMin: scale = MinuteMs;
				default: scale = HourMs;
			endcase
			// exact sum, then fold into one day; a negative whole day lands on 0
			total = longint'(now) + longint'($signed(c.amount)) * scale;
			total = total % DayMs;
			if (total < 0)
				total += DayMs;
			now = 32'(total);
		end else begin
			hh = 32'(now / HourMs);
			mm = 32'((now / MinuteMs) % 60);
			ss = 32'((now / SecondMs) % 60);
			ff = 32'(now % SecondMs);
			// unsigned compare: negative values are out of range too
			case (c.unit)
				UnitMs:  if (raw < 1000) ff = raw; else rejected = 1'b1;
				UnitSec: if (raw < 60) ss = raw; else rejected = 1'b1;
				UnitMin: if (raw < 60) mm = raw; else rejected = 1'b1;
				default: if (raw < 24) hh = raw; else rejected = 1'b1;
			endcase
			if (!rejected)
				now = 32'(hh * HourMs + mm * MinuteMs + ss * SecondMs + ff);
		end
		clock_ms = 27'(now);
		r.hours        = 5'(clock_ms / HourMs);
		r.minutes      = 6'((clock_ms / MinuteMs) % 60);
		r.seconds_part = 6'((clock_ms / SecondMs) % 60);
		r.millis       = 10'(clock_ms % SecondMs);
		r.bad_value    = rejected;
		return r;
	endfunction

	task automatic check_field(input string label, input int unsigned want,
			input int unsigned got, inout int faults);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
			faults++;
		end
	endtask

	// Predict on command beats, compare on response beats
	always @(posedge clk) begin
		tdr_out_t want;
		int       faults;
		faults = 0;
		if (!arst_n) begin
			clock_ms = '0;
			expected_times.delete();
			errors    <= 0;
			responses <= 0;
			rejects   <= 0;
		end else begin
			if (cmd_valid && cmd_ready)
				expected_times.push_back(predict_time(cmd));
			if (rsp_valid && rsp_ready) begin
				if (expected_times.size() == 0) begin
					$display("%0t: response beat with no command waiting, got %p",
						$time, rsp);
					faults++;
				end else begin
					want = expected_times.pop_front();
					check_field("hours", 32'(want.hours), 32'(rsp.hours), faults);
					check_field("minutes", 32'(want.minutes), 32'(rsp.minutes), faults);
					check_field("seconds_part", 32'(want.seconds_part),
						32'(rsp.seconds_part), faults);
					check_field("millis", 32'(want.millis), 32'(rsp.millis), faults);
					check_field("bad_value", 32'(want.bad_value),
						32'(rsp.bad_value), faults);
				end
				responses <= responses + 1;
				if (rsp.bad_value)
					rejects <= rejects + 1;
			end
			errors <= errors + faults;
		end
		pending <= expected_times.size();
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the time-of-day register
// Drives add and set commands, directed corner cases first, then random
// commands and set/rewind sequences, with random idling on both channels.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
	import tdr_pkg::*;

	localparam int unsigned RandomCommands = 1350;
	localparam int unsigned StallLimit     = 4000;
	localparam int unsigned DrainCycles    = 40;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cmd_valid = 1'b0;
	logic     cmd_ready;
	tdr_in_t  cmd = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	tdr_out_t rsp;

	int          errors, pending, responses, rejects;
	int unsigned adds_sent = 0;
	int unsigned sets_sent = 0;
	int unsigned quiet_cycles = 0;
	logic        steady = 1'b0;	// no idling on either side while set

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	time_of_day_register DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	tdr_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending),
		.responses (responses),
		.rejects   (rejects)
	);

	// Response side stalls at random
	always @(negedge clk)
		rsp_ready <= steady || ($urandom_range(99) >= 8);

	// Watchdog: too long without any beat ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= StallLimit) begin
				$display("%0t: no beat for %0d cycles", $time, StallLimit);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// One command beat; called and returns at a falling edge
	task automatic issue_command(input logic kind, input logic [1:0] unit,
			input logic signed [31:0] amount);
		int unsigned gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 8)
			gap = $urandom_range(3, 1);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{kind: kind, unit: unit, amount: amount};
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
		if (kind == KindAdd)
			adds_sent++;
		else
			sets_sent++;
	endtask

	// Back to midnight through four valid sets
	task automatic set_midnight();
		issue_command(KindSet, UnitHour, 0);
		issue_command(KindSet, UnitMin, 0);
		issue_command(KindSet, UnitSec, 0);
		issue_command(KindSet, UnitMs, 0);
	endtask

	// Single command with a mix of small, in-range, extreme and full-width counts
	task automatic random_command();
		logic        kind;
		logic [1:0]  unit;
		logic [31:0] amount;
		int unsigned span;
		kind = 1'($urandom_range(1));
		unit = 2'($urandom_range(3));
		case (unit)
			UnitMs:   span = 1000;
			UnitHour: span = 24;
			default:  span = 60;
		endcase
		case ($urandom_range(9))
			0, 1, 2: amount = $urandom_range(200) - 100;
			3, 4, 5: amount = $urandom_range(span + 1);
			6, 7:    amount = $urandom;
			8: begin
				case ($urandom_range(3))
					0:       amount = 32'h7fff_ffff;
					1:       amount = 32'h8000_0000;
					2:       amount = 32'hffff_ffff;
					default: amount = 32'h0;
				endcase
			end
			default: amount = -$urandom_range(30, 1);
		endcase
		issue_command(kind, unit, amount);
	endtask

	initial begin
		int unsigned days;
		logic [1:0]  unit;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// largest valid value of each component
		issue_command(KindSet, UnitHour, 23);
		issue_command(KindSet, UnitMin, 59);
		issue_command(KindSet, UnitSec, 59);
		issue_command(KindSet, UnitMs, 999);
		// wrap forward past midnight and back
		issue_command(KindAdd, UnitMs, 1);
		issue_command(KindAdd, UnitMs, -1);
		// out-of-range sets keep the time
		issue_command(KindSet, UnitHour, 24);
		issue_command(KindSet, UnitMin, 60);
		issue_command(KindSet, UnitSec, 60);
		issue_command(KindSet, UnitMs, 1000);
		issue_command(KindSet, UnitHour, -1);
		issue_command(KindSet, UnitMs, 32'h8000_0000);
		// extreme counts in every unit
		issue_command(KindAdd, UnitMs, 32'h7fff_ffff);
		issue_command(KindAdd, UnitSec, 32'h8000_0000);
		issue_command(KindAdd, UnitMin, 32'h7fff_ffff);
		issue_command(KindAdd, UnitHour, 32'h8000_0000);
		issue_command(KindAdd, UnitHour, 0);
		// whole negative days from midnight must give midnight
		set_midnight();
		issue_command(KindAdd, UnitHour, -24);
		issue_command(KindAdd, UnitMs, -86400000);
		issue_command(KindAdd, UnitMin, -2880);

		// random part: single commands, full set sequences, rewinds by whole days
		while (adds_sent + sets_sent < RandomCommands + 24) begin
			steady <= (adds_sent + sets_sent >= 500) && (adds_sent + sets_sent < 800);
			case ($urandom_range(99)) inside
				[0:19]: begin
					issue_command(KindSet, UnitHour, $urandom_range(23));
					issue_command(KindSet, UnitMin, $urandom_range(59));
					issue_command(KindSet, UnitSec, $urandom_range(59));
					issue_command(KindSet, UnitMs, $urandom_range(999));
				end
				[20:29]: begin
					set_midnight();
					days = $urandom_range(24, 1);
					unit = 2'($urandom_range(3));
					case (unit)
						UnitMs:  issue_command(KindAdd, unit, -days * 86400000);
						UnitSec: issue_command(KindAdd, unit, -days * 86400);
						UnitMin: issue_command(KindAdd, unit, -days * 1440);
						default: issue_command(KindAdd, unit, -days * 24);
					endcase
				end
				default: random_command();
			endcase
		end
		cmd_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d add and %0d set commands; %0d responses checked, %0d sets rejected.",
			adds_sent, sets_sent, responses, rejects);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
rtl/tdr_pkg.sv
rtl/tdr_digit_step.sv
rtl/tdr_update.sv
rtl/time_of_day_register.sv
rtl/tdr_checker.sv
bench/tdr_checker.sv
bench/testbench.sv
